// ===== hdl/uctc_pkg.sv =====
package uctc_pkg;

   localparam int NSTAGE = 12;

   localparam logic [37:0] MAX_UNIX_SECONDS = 38'd253402300799;

   localparam logic [1:0] CSR_OFFSET_MIN = 2'd0;
   localparam logic [1:0] CSR_OFFSET_MAX = 2'd1;

   localparam logic [11:0] OFFSET_MIN_RESET = 12'hD30;  // -720
   localparam logic [10:0] OFFSET_MAX_RESET = 11'd840;

   typedef struct packed {
      logic               op;
      logic               ok;
      // seconds to civil
      logic [37:0]        lb;
      logic [21:0]        q;
      logic [21:0]        z;
      logic [16:0]        sod;
      logic [4:0]         era;
      logic [4:0]         hour;
      logic [11:0]        ms;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [17:0]        doe;
      logic [6:0]         a;
      logic [2:0]         b;
      logic               c;
      logic [17:0]        t;
      logic [8:0]         yoe;
      logic [8:0]         doy;
      logic [3:0]         mp;
      // civil to seconds
      logic [13:0]        yr;
      logic [3:0]         mo;
      logic [4:0]         dy;
      logic [14:0]        yb;
      logic [9:0]         doy0;
      logic signed [18:0] hmso;
      logic [7:0]         q100;
      logic [5:0]         u_era;
      logic [8:0]         u_yoe;
      logic [17:0]        u_doe;
      logic signed [23:0] u_days;
      logic signed [40:0] u_prod;
      logic signed [40:0] utc;
      // result
      logic [37:0]        res_utc;
      logic [13:0]        res_year;
      logic [3:0]         res_month;
      logic [4:0]         res_day;
   } pipe_type;

   // first day of each month counted from March
   function automatic logic [8:0] month_offset(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
      logic [4:0] r;
      case (mo)
         4'd2:    r = leap ? 5'd29 : 5'd28;
         4'd4:    r = 5'd30;
         4'd6:    r = 5'd30;
         4'd9:    r = 5'd30;
         4'd11:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

   // yoe / 100 for yoe below 400
   function automatic logic [1:0] yoe_century(input logic [8:0] yoe);
      logic [1:0] r;
      if (yoe >= 9'd300) begin
         r = 2'd3;
      end else if (yoe >= 9'd200) begin
         r = 2'd2;
      end else if (yoe >= 9'd100) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

endpackage

// ===== hdl/unix_civil_time_converter.sv =====
// Unix seconds <-> local civil time converter.
// Request channel (req_*): one beat per conversion. req_opcode 0 turns
// req_unix_seconds_in plus req_utc_offset (minutes) into local year, month,
// day, hour, minute, second. req_opcode 1 turns a local date and time plus
// offset into Unix seconds, after checking the fields and the offset window.
// Response channel (rsp_*): one beat per request, in order. rsp_valid_res is
// low for a rejected request, with all other fields zero; unused fields of a
// good result are zero.
// Data flows through a 12-register pipeline; each stage does small constant
// multiplies or compare-and-correct steps. Throughput is one beat per cycle
// while rsp_stall is low. Each stage holds while the one after it is full
// and stalled, so bubbles close up and rsp_stall backs up into req_stall
// only once the pipeline is full.
// csr_*: write-only registers, offset_min (index 0) and offset_max (index 1).
// Write them only while no request is in flight.
// Synchronous reset empties the pipeline and loads offset_min = -720 and
// offset_max = 840.
module unix_civil_time_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [37:0] req_unix_seconds_in,
   input  logic [11:0] req_utc_offset,
   input  logic [13:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [37:0] rsp_unix_seconds_out,
   output logic [13:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import uctc_pkg::*;

   logic [11:0] offset_min_ff;
   logic [10:0] offset_max_ff;

   pipe_type    st_ff [NSTAGE];
   pipe_type    st_in [NSTAGE];
   logic        v_ff  [NSTAGE];
   logic        v_in  [NSTAGE];
   logic        en    [NSTAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_min_ff <= OFFSET_MIN_RESET;
         offset_max_ff <= OFFSET_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_MIN: offset_min_ff <= csr_wdata;
            CSR_OFFSET_MAX: offset_max_ff <= csr_wdata[10:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      en[NSTAGE-1] = !v_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = req_valid;
      for (int k = 1; k < NSTAGE; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in[k];
         end
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      pipe_type           s;
      logic signed [18:0] off60;
      logic signed [39:0] lbs;
      logic [16:0]        hms;
      logic [3:0]         mp_in;
      logic [53:0]        p54;
      logic [21:0]        p22a;
      logic [21:0]        p22b;
      logic [31:0]        r32;
      logic [9:0]         rem;
      logic [15:0]        r16;
      logic [7:0]         q100f;
      logic [26:0]        p27;
      logic [22:0]        p23;
      logic [25:0]        p26;
      logic [20:0]        p21;
      logic [18:0]        p19;
      logic [24:0]        dd;
      logic [17:0]        r18;
      logic [6:0]         af;
      logic [2:0]         bf;
      logic [16:0]        r17;
      logic [11:0]        r12;
      logic [27:0]        p28;
      logic [10:0]        w;
      logic [14:0]        p15;
      logic [10:0]        r11;
      logic [3:0]         m;
      logic [9:0]         d10;

      // stage 0: input terms
      s       = st_ff[0];
      off60   = 19'(signed'(req_utc_offset)) * 19'sd60;
      lbs     = signed'({2'b00, req_unix_seconds_in}) + 40'(off60) + 40'sd172800;
      hms     = 17'(17'(req_hour_in) * 17'd3600 + 17'(req_minute_in) * 17'd60
                + 17'(req_second_in));
      mp_in   = (req_month_in > 4'd2) ? 4'(req_month_in - 4'd3) : 4'(req_month_in + 4'd9);
      s.op    = req_opcode;
      s.lb    = lbs[37:0];
      s.yr    = req_year_in;
      s.mo    = req_month_in;
      s.dy    = req_day_in;
      s.yb    = 15'(req_year_in) + 15'd400 - 15'(req_month_in <= 4'd2);
      s.doy0  = 10'(month_offset(mp_in)) + 10'(req_day_in) - 10'd1;
      s.hmso  = signed'({2'b00, hms}) - off60;
      if (req_opcode) begin
         s.ok = (req_month_in >= 4'd1) && (req_month_in <= 4'd12) && (req_day_in >= 5'd1)
                && (req_hour_in <= 5'd23) && (req_minute_in <= 6'd59)
                && (req_second_in <= 6'd59)
                && (signed'(req_utc_offset) >= signed'(offset_min_ff))
                && (signed'(req_utc_offset) <= signed'({1'b0, offset_max_ff}));
      end else begin
         s.ok = (req_unix_seconds_in <= MAX_UNIX_SECONDS);
      end
      st_in[0] = s;

      // stage 1: reciprocal estimates
      s       = st_ff[0];
      p54     = {23'b0, s.lb[37:7]} * 54'd6362914;
      s.q     = p54[53:32];
      p22a    = 22'(s.yr) * 22'd163;
      s.q100  = p22a[21:14];
      p22b    = 22'(s.yb) * 22'd81;
      s.u_era = p22b[20:15];
      st_in[1] = s;

      // stage 2: day count and seconds of day; leap year and era
      s       = st_ff[1];
      r32     = 32'(s.lb[37:7]) - 32'(s.q) * 32'd675;
      if (r32 >= 32'd675) begin
         s.q = s.q + 22'd1;
         rem = 10'(r32 - 32'd675);
      end else begin
         rem = 10'(r32);
      end
      s.sod   = {rem, s.lb[6:0]};
      r16     = 16'(s.yr) - 16'(s.q100) * 16'd100;
      q100f   = s.q100;
      if (r16 >= 16'd100) begin
         q100f = q100f + 8'd1;
         r16   = r16 - 16'd100;
      end
      if (s.op) begin
         s.ok = s.ok && (s.dy <= month_days(s.mo, (s.yr[1:0] == 2'b00)
                && ((r16 != 16'd0) || (q100f[1:0] == 2'b00))));
      end
      r16     = 16'(s.yb) - 16'(s.u_era) * 16'd400;
      if (r16 >= 16'd400) begin
         s.u_era = s.u_era + 6'd1;
         r16     = r16 - 16'd400;
      end
      s.u_yoe = r16[8:0];
      st_in[2] = s;

      // stage 3
      s       = st_ff[2];
      s.z     = s.q + 22'd719466;
      p27     = 27'(s.z) * 27'd28;
      s.era   = p27[26:22];
      p23     = 23'(s.sod) * 23'd36;
      s.hour  = p23[21:17];
      s.u_doe = 18'(s.u_yoe) * 18'd365 + 18'(s.u_yoe[8:2])
                - 18'(yoe_century(s.u_yoe)) + 18'(s.doy0);
      st_in[3] = s;

      // stage 4
      s       = st_ff[3];
      p23     = 23'(s.z) - 23'(s.era) * 23'd146097;
      if (p23 >= 23'd146097) begin
         s.era = s.era + 5'd1;
         p23   = p23 - 23'd146097;
      end
      s.doe   = p23[17:0];
      r17     = s.sod - 17'(s.hour) * 17'd3600;
      if (r17 >= 17'd3600) begin
         s.hour = s.hour + 5'd1;
         r17    = r17 - 17'd3600;
      end
      s.ms    = r17[11:0];
      dd      = 25'(s.u_era) * 25'd146097 + 25'(s.u_doe);
      s.u_days = 24'(signed'({1'b0, dd}) - 26'sd865565);
      st_in[4] = s;

      // stage 5
      s        = st_ff[4];
      p26      = 26'(s.doe) * 26'd179;
      s.a      = p26[24:18];
      p21      = 21'(s.doe) * 21'd7;
      s.b      = p21[20:18];
      s.c      = (s.doe == 18'd146096);
      p19      = 19'(s.ms) * 19'd68;
      s.minute = p19[17:12];
      s.u_prod = 41'(s.u_days) * 41'sd86400;
      st_in[5] = s;

      // stage 6
      s       = st_ff[5];
      af      = s.a;
      r18     = s.doe - 18'(s.a) * 18'd1460;
      if (r18 >= 18'd1460) begin
         af = af + 7'd1;
      end
      bf      = s.b;
      r18     = s.doe - 18'(s.b) * 18'd36524;
      if (r18 >= 18'd36524) begin
         bf = bf + 3'd1;
      end
      s.t     = s.doe - 18'(af) + 18'(bf) - 18'(s.c);
      r12     = s.ms - 12'(s.minute) * 12'd60;
      if (r12 >= 12'd60) begin
         s.minute = s.minute + 6'd1;
         r12      = r12 - 12'd60;
      end
      s.second = r12[5:0];
      s.utc    = s.u_prod + 41'(s.hmso);
      st_in[6] = s;

      // stage 7
      s       = st_ff[6];
      p28     = 28'(s.t) * 28'd718;
      s.yoe   = p28[26:18];
      if (s.op) begin
         s.ok = s.ok && !s.utc[40] && (s.utc[39:0] <= {2'b00, MAX_UNIX_SECONDS});
      end
      s.res_utc = s.utc[37:0];
      st_in[7] = s;

      // stage 8
      s       = st_ff[7];
      r18     = s.t - 18'(s.yoe) * 18'd365;
      if (r18 >= 18'd365) begin
         s.yoe = s.yoe + 9'd1;
      end
      st_in[8] = s;

      // stage 9
      s       = st_ff[8];
      r18     = s.doe - (18'(s.yoe) * 18'd365 + 18'(s.yoe[8:2]) - 18'(yoe_century(s.yoe)));
      s.doy   = r18[8:0];
      st_in[9] = s;

      // stage 10
      s       = st_ff[9];
      w       = 11'(s.doy) * 11'd5 + 11'd2;
      p15     = 15'(w) * 15'd13;
      s.mp    = p15[14:11];
      st_in[10] = s;

      // stage 11: date fields and result
      s       = st_ff[10];
      w       = 11'(s.doy) * 11'd5 + 11'd2;
      r11     = w - 11'(s.mp) * 11'd153;
      if (r11 >= 11'd153) begin
         s.mp = s.mp + 4'd1;
      end
      d10     = 10'(s.doy) - 10'(month_offset(s.mp)) + 10'd1;
      m       = (s.mp < 4'd10) ? 4'(s.mp + 4'd3) : 4'(s.mp - 4'd9);
      s.res_day   = d10[4:0];
      s.res_month = m;
      s.res_year  = 14'(s.yoe) + 14'(s.era) * 14'd400 + 14'(m <= 4'd2);
      if (!s.ok || s.op) begin
         s.res_day   = '0;
         s.res_month = '0;
         s.res_year  = '0;
         s.hour      = '0;
         s.minute    = '0;
         s.second    = '0;
      end
      if (!s.ok || !s.op) begin
         s.res_utc = '0;
      end
      st_in[11] = s;
   end

   assign rsp_valid            = v_ff[NSTAGE-1];
   assign rsp_valid_res        = st_ff[NSTAGE-1].ok;
   assign rsp_unix_seconds_out = st_ff[NSTAGE-1].res_utc;
   assign rsp_year_out         = st_ff[NSTAGE-1].res_year;
   assign rsp_month_out        = st_ff[NSTAGE-1].res_month;
   assign rsp_day_out          = st_ff[NSTAGE-1].res_day;
   assign rsp_hour_out         = st_ff[NSTAGE-1].hour;
   assign rsp_minute_out       = st_ff[NSTAGE-1].minute;
   assign rsp_second_out       = st_ff[NSTAGE-1].second;

endmodule

// ===== hdl/uctc_checker.sv =====
module uctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_valid_res,
   input logic [37:0] rsp_unix_seconds_out,
   input logic [13:0] rsp_year_out,
   input logic [3:0]  rsp_month_out,
   input logic [4:0]  rsp_day_out,
   input logic [4:0]  rsp_hour_out,
   input logic [5:0]  rsp_minute_out,
   input logic [5:0]  rsp_second_out
);
   import uctc_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res)
         && $stable(rsp_unix_seconds_out) && $stable(rsp_year_out)
         && $stable(rsp_second_out))
      else $error("stalled response beat changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_unix_seconds_out == 38'd0
         && rsp_year_out == 14'd0 && rsp_month_out == 4'd0 && rsp_day_out == 5'd0
         && rsp_hour_out == 5'd0 && rsp_minute_out == 6'd0 && rsp_second_out == 6'd0)
      else $error("rejected beat carries data");

   a_civil_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res && rsp_month_out != 4'd0 |->
         rsp_unix_seconds_out == 38'd0 && rsp_month_out <= 4'd12 && rsp_day_out != 5'd0
         && rsp_hour_out <= 5'd23 && rsp_minute_out <= 6'd59 && rsp_second_out <= 6'd59)
      else $error("civil result out of range");

   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_unix_seconds_out <= MAX_UNIX_SECONDS)
      else $error("seconds result beyond range");

endmodule

bind unix_civil_time_converter uctc_checker u_uctc_checker (.*);
